>>> sv/adrs_pkg.sv
// shared types and constants of the downmix / resample / pcm16 block
package adrs_pkg;

    // payload widths
    localparam int SAMPLE_W = 24;
    localparam int PCM_W    = 16;
    localparam int CHAN_W   = 4;
    localparam int RATE_W   = 18;
    localparam int ORATE_W  = 20;   // output rate after saturation at four times input rate
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // run state widths
    localparam int FSUM_W  = 27;
    localparam int MCNT_W  = 25;
    localparam int IDX_W   = 27;
    localparam int POS_W   = 45;
    localparam int TCNT_W  = 28;
    localparam int NCNT_W  = 4;

    // shared multiplier
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // shared divider
    localparam int DIV_N_W = 60;
    localparam int DIV_D_W = 44;
    localparam int DIV_Q_W = 28;
    localparam int DIV_C_W = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RATE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE   = 2'd2;

    // configuration reset values
    localparam logic [CHAN_W-1:0] CHANNEL_COUNT_RST = 4'd1;
    localparam logic [RATE_W-1:0] INPUT_RATE_RST    = 18'd48000;
    localparam logic [RATE_W-1:0] OUTPUT_RATE_RST   = 18'd16000;

    // limits
    localparam logic [CHAN_W-1:0] MAX_CHANNELS     = 4'd8;
    localparam logic [MCNT_W-1:0] MAX_MONO_SAMPLES = 25'd16777216;
    localparam logic [NCNT_W-1:0] MAX_RESULTS      = 4'd8;
    localparam logic [IDX_W-1:0]  IDX_LAST         = 27'h7FFFFFF;
    localparam logic [DIV_Q_W-1:0] MONO_BIAS       = 28'h4000000;
    localparam logic [PCM_W-1:0]  PCM_OFFSET       = 16'd32767;

    // shift codes of the divider: quotient bits developed per division
    typedef enum logic [1:0] {
        DIV_S16 = 2'd0,
        DIV_S28 = 2'd1,
        DIV_S45 = 2'd2
    } div_shift_t;

    typedef struct packed {
        logic       start;
        div_shift_t shift;
    } div_req_t;

    // sequencer states
    typedef enum logic [20:0] {
        ST_IDLE      = 21'h000001,
        ST_MONO_DIV  = 21'h000002,
        ST_DISPATCH  = 21'h000004,
        ST_LIM_MUL   = 21'h000008,
        ST_LIM_SAVE  = 21'h000010,
        ST_LOOP_CHK  = 21'h000020,
        ST_POS_MUL   = 21'h000040,
        ST_POS_CHK   = 21'h000080,
        ST_MOD_DIV   = 21'h000100,
        ST_PCM_M1    = 21'h000200,
        ST_PCM_M2    = 21'h000400,
        ST_PCM_SUM   = 21'h000800,
        ST_PCM_DIV   = 21'h001000,
        ST_EMIT      = 21'h002000,
        ST_T_MUL     = 21'h004000,
        ST_T_DIV     = 21'h008000,
        ST_T_WAIT    = 21'h010000,
        ST_LAST_MUL  = 21'h020000,
        ST_LAST_SAVE = 21'h040000,
        ST_FLOOP_CHK = 21'h080000,
        ST_CLEAR     = 21'h100000
    } state_t;

endpackage

>>> sv/adrs_if.sv
// valid/ready channels for channel samples and pcm results
interface adrs_in_if;
    import adrs_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                final_req;

    modport source (output valid, output sample, output final_req, input ready);
    modport sink   (input valid, input sample, input final_req, output ready);
endinterface

interface adrs_out_if;
    import adrs_pkg::*;
    logic             valid;
    logic             ready;
    logic [PCM_W-1:0] pcm;
    logic             run_end;
    logic             empty_res;

    modport source (output valid, output pcm, output run_end, output empty_res, input ready);
    modport sink   (input valid, input pcm, input run_end, input empty_res, output ready);
endinterface

>>> sv/audio_downmix_resample_pcm16.sv
// top level: frame downmix, linear interpolation resampler and pcm16 output
//
// samples: interleaved channel samples (Q2.22) with final_req on the last one
// of a recording. results: pcm16 mono samples with run_end on the last result
// of a recording and empty_res when the recording had no complete frame.
// cfg_we / cfg_index / cfg_data write channel_count, input_rate, output_rate;
// write only while the block is idle.
// Closing a frame adds a pass through the shared divider to form the mono
// average. Each result computed takes one pass through the multiplier for
// its source position, a division for the interpolation fraction (none past
// the last source sample), two multiplies and a division for the pcm value.
// A final sample adds a multiply and a division to derive the output count.
// At most 8 results per sample.
// One iterative divider and one multiplier are shared by all of these steps,
// so the block takes one sample at a time and drops ready while it works.
// Results wait in an output register; a stalled receiver holds the block
// only when the next result is ready to be written there.
// Reset restores the register defaults and clears all recording state.
module audio_downmix_resample_pcm16 (
    input  logic                                clk,
    input  logic                                rst_n,
    adrs_in_if.sink                             samples,
    adrs_out_if.source                          results,
    input  logic                                cfg_we,
    input  logic [adrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [adrs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import adrs_pkg::*;

    // configuration
    logic [CHAN_W-1:0] channel_count_reg;
    logic [RATE_W-1:0] input_rate_reg;
    logic [RATE_W-1:0] output_rate_reg;

    // recording state
    state_t                     state_reg;
    state_t                     ret_state_reg;
    logic signed [FSUM_W-1:0]   frame_sum_reg;
    logic [CHAN_W-1:0]          channels_seen_reg;
    logic signed [SAMPLE_W-1:0] previous_mono_reg;
    logic signed [SAMPLE_W-1:0] current_mono_reg;
    logic [MCNT_W-1:0]          mono_count_reg;
    logic [IDX_W-1:0]           nxt_reg;
    logic [PCM_W-1:0]           held_output_reg;
    logic                       held_valid_reg;
    logic                       fin_reg;
    logic                       newmono_reg;
    logic                       tail_reg;
    logic [NCNT_W-1:0]          n_reg;
    logic [POS_W-1:0]           limpos_reg;
    logic [TCNT_W-1:0]          t_reg;
    logic [ORATE_W-1:0]         r_reg;
    logic signed [MUL_P_W-1:0]  acc_reg;

    // staged and registered result
    logic [PCM_W-1:0] emit_pcm_reg;
    logic             emit_end_reg;
    logic             emit_empty_reg;
    logic             out_valid_reg;
    logic [PCM_W-1:0] out_pcm_reg;
    logic             out_end_reg;
    logic             out_empty_reg;

    // effective configuration
    logic [CHAN_W-1:0]  c_eff;
    logic [RATE_W-1:0]  ir_eff;
    logic [RATE_W-1:0]  or_min;
    logic [ORATE_W-1:0] or_cap;
    logic [ORATE_W-1:0] orr_eff;
    logic               hold;

    assign c_eff  = (channel_count_reg == 4'd0) ? 4'd1 :
                    (channel_count_reg > MAX_CHANNELS) ? MAX_CHANNELS : channel_count_reg;
    assign ir_eff = (input_rate_reg == 18'd0) ? 18'd1 : input_rate_reg;
    assign or_min = (output_rate_reg == 18'd0) ? 18'd1 : output_rate_reg;
    assign or_cap = {ir_eff, 2'b00};
    assign orr_eff = ({2'b00, or_min} > or_cap) ? or_cap : {2'b00, or_min};
    assign hold   = orr_eff < {2'b00, ir_eff};

    // input transfer and frame accumulation
    logic                     accept_in;
    logic signed [FSUM_W-1:0] fs_new;
    logic [CHAN_W-1:0]        cs_new;
    logic                     frame_done;
    logic [31:0]              mono_num;

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept_in  = samples.valid && samples.ready;
    assign fs_new     = frame_sum_reg + {{(FSUM_W-SAMPLE_W){samples.sample[SAMPLE_W-1]}},
                                         samples.sample};
    assign cs_new     = channels_seen_reg + 4'd1;
    assign frame_done = cs_new >= c_eff;
    // 2*sum + c, biased by 2c * 2^26 so the dividend stays positive
    assign mono_num   = {{4{fs_new[FSUM_W-1]}}, fs_new, 1'b0} + {28'd0, c_eff}
                        + {1'b0, c_eff, 27'd0};

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic [MCNT_W-1:0]         mc_m1;
    logic signed [SAMPLE_W-1:0] pa;
    logic signed [SAMPLE_W:0]   pd;

    assign mc_m1 = mono_count_reg - 25'd1;
    assign pa    = tail_reg ? current_mono_reg : previous_mono_reg;
    assign pd    = tail_reg ? '0 : ({current_mono_reg[SAMPLE_W-1], current_mono_reg}
                                   - {previous_mono_reg[SAMPLE_W-1], previous_mono_reg});

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg) inside
            ST_LIM_MUL, ST_LAST_MUL:
            begin
                mul_a = {3'd0, mc_m1};
                mul_b = {1'b0, orr_eff};
            end
            ST_T_MUL:
            begin
                mul_a = {3'd0, mono_count_reg};
                mul_b = {1'b0, orr_eff};
            end
            ST_POS_MUL:
            begin
                mul_a = {1'b0, nxt_reg};
                mul_b = {3'd0, ir_eff};
            end
            ST_PCM_M1:
            begin
                mul_a = {{(MUL_A_W-SAMPLE_W){pa[SAMPLE_W-1]}}, pa};
                mul_b = {1'b0, orr_eff};
            end
            ST_PCM_M2:
            begin
                mul_a = {{(MUL_A_W-SAMPLE_W-1){pd[SAMPLE_W]}}, pd};
                mul_b = {1'b0, r_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    adrs_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // position compare
    logic [POS_W-1:0] pos;
    logic             pos_past;

    assign pos      = prod[POS_W-1:0];
    assign pos_past = pos >= limpos_reg;

    // pcm scaling: clamp, shift to [0, 2*lim], scale by 65534 and round
    logic signed [MUL_P_W:0] num_s;
    logic signed [MUL_P_W:0] lim_s;
    logic signed [MUL_P_W:0] num_c;
    logic signed [MUL_P_W:0] n2_full;
    logic [DIV_D_W-1:0]      n2;
    logic [DIV_N_W-1:0]      pcm_num;
    logic [PCM_W-1:0]        pcm_v;

    assign num_s   = {acc_reg[MUL_P_W-1], acc_reg} + {prod[MUL_P_W-1], prod};
    assign lim_s   = {8'd0, orr_eff, 22'd0};
    assign num_c   = (num_s > lim_s) ? lim_s : ((num_s < -lim_s) ? -lim_s : num_s);
    assign n2_full = num_c + lim_s;
    assign n2      = n2_full[DIV_D_W-1:0];
    assign pcm_num = {n2, 16'd0} - {15'd0, n2, 1'b0} + {18'd0, orr_eff, 22'd0};

    // output count numerator: 2*N*out + in
    logic [46:0] t_num;
    assign t_num = {1'b0, prod[POS_W-1:0], 1'b0} + {29'd0, ir_eff};

    // shared divider
    div_req_t           div_req;
    logic [DIV_N_W-1:0] div_num;
    logic [DIV_D_W-1:0] div_den;
    logic               div_done;
    logic [DIV_Q_W-1:0] div_quot;
    logic [DIV_D_W-1:0] div_rem;

    // divider request select
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.shift = DIV_S45;
        div_num = '0;
        div_den = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                div_req.start = accept_in && frame_done;
                div_req.shift = DIV_S28;
                div_num = {28'd0, mono_num};
                div_den = {39'd0, c_eff, 1'b0};
            end
            ST_POS_CHK:
            begin
                div_req.start = !pos_past;
                div_req.shift = DIV_S45;
                div_num = {15'd0, pos};
                div_den = {24'd0, orr_eff};
            end
            ST_PCM_SUM:
            begin
                div_req.start = 1'b1;
                div_req.shift = DIV_S16;
                div_num = pcm_num;
                div_den = {1'b0, orr_eff, 23'd0};
            end
            ST_T_DIV:
            begin
                div_req.start = 1'b1;
                div_req.shift = DIV_S28;
                div_num = {13'd0, t_num};
                div_den = {25'd0, ir_eff, 1'b0};
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    adrs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    // loop conditions
    logic [SAMPLE_W-1:0] mono_v;
    logic [TCNT_W-1:0]   nxt_w;
    logic                last_out;
    logic                held_due;
    logic                floop_run;
    logic                out_free;

    assign mono_v    = SAMPLE_W'(div_quot - MONO_BIAS);
    assign pcm_v     = div_quot[PCM_W-1:0] - PCM_OFFSET;
    assign nxt_w     = {1'b0, nxt_reg};
    assign last_out  = (nxt_w + 28'd1 >= t_reg) || (nxt_reg == IDX_LAST - 27'd1)
                       || (n_reg == MAX_RESULTS - 4'd1);
    assign held_due  = (nxt_w - 28'd1) < t_reg;
    assign floop_run = (nxt_w < t_reg) && (nxt_reg != IDX_LAST) && (n_reg < MAX_RESULTS);
    assign out_free  = !out_valid_reg || results.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CHANNEL_COUNT_RST;
            input_rate_reg    <= INPUT_RATE_RST;
            output_rate_reg   <= OUTPUT_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHAN_W-1:0];
                CFG_INPUT_RATE:    input_rate_reg    <= cfg_data;
                CFG_OUTPUT_RATE:   output_rate_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            ret_state_reg     <= ST_IDLE;
            frame_sum_reg     <= '0;
            channels_seen_reg <= '0;
            previous_mono_reg <= '0;
            current_mono_reg  <= '0;
            mono_count_reg    <= '0;
            nxt_reg           <= '0;
            held_output_reg   <= '0;
            held_valid_reg    <= 1'b0;
            fin_reg           <= 1'b0;
            newmono_reg       <= 1'b0;
            tail_reg          <= 1'b0;
            n_reg             <= '0;
            limpos_reg        <= '0;
            t_reg             <= '0;
            r_reg             <= '0;
            acc_reg           <= '0;
            emit_pcm_reg      <= '0;
            emit_end_reg      <= 1'b0;
            emit_empty_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept_in)
                    begin
                        fin_reg     <= samples.final_req;
                        newmono_reg <= 1'b0;
                        if (frame_done)
                        begin
                            frame_sum_reg     <= '0;
                            channels_seen_reg <= '0;
                            state_reg         <= ST_MONO_DIV;
                        end
                        else
                        begin
                            frame_sum_reg     <= fs_new;
                            channels_seen_reg <= cs_new;
                            state_reg         <= ST_DISPATCH;
                        end
                    end
                end
                ST_MONO_DIV:
                begin
                    if (div_done)
                    begin
                        if (mono_count_reg < MAX_MONO_SAMPLES)
                        begin
                            previous_mono_reg <= current_mono_reg;
                            current_mono_reg  <= mono_v;
                            mono_count_reg    <= mono_count_reg + 25'd1;
                            newmono_reg       <= 1'b1;
                        end
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH:
                begin
                    if (fin_reg)
                    begin
                        if (mono_count_reg == '0)
                        begin
                            // empty recording marker
                            emit_pcm_reg   <= '0;
                            emit_end_reg   <= 1'b1;
                            emit_empty_reg <= 1'b1;
                            ret_state_reg  <= ST_CLEAR;
                            state_reg      <= ST_EMIT;
                        end
                        else
                        begin
                            state_reg <= ST_T_MUL;
                        end
                    end
                    else if (newmono_reg && mono_count_reg >= 25'd2)
                    begin
                        state_reg <= ST_LIM_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_LIM_MUL:
                begin
                    state_reg <= ST_LIM_SAVE;
                end
                ST_LIM_SAVE:
                begin
                    limpos_reg <= pos;
                    n_reg      <= '0;
                    if (!hold && held_valid_reg)
                    begin
                        emit_pcm_reg   <= held_output_reg;
                        emit_end_reg   <= 1'b0;
                        emit_empty_reg <= 1'b0;
                        held_valid_reg <= 1'b0;
                        ret_state_reg  <= ST_LOOP_CHK;
                        state_reg      <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_LOOP_CHK;
                    end
                end
                ST_LOOP_CHK:
                begin
                    if (nxt_reg == IDX_LAST || n_reg >= MAX_RESULTS)
                        state_reg <= ST_IDLE;
                    else
                        state_reg <= ST_POS_MUL;
                end
                ST_POS_MUL:
                begin
                    state_reg <= ST_POS_CHK;
                end
                ST_POS_CHK:
                begin
                    if (!pos_past)
                    begin
                        tail_reg  <= 1'b0;
                        state_reg <= ST_MOD_DIV;
                    end
                    else if (fin_reg)
                    begin
                        // past the last source sample: repeat it
                        tail_reg  <= 1'b1;
                        r_reg     <= '0;
                        state_reg <= ST_PCM_M1;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MOD_DIV:
                begin
                    if (div_done)
                    begin
                        r_reg     <= div_rem[ORATE_W-1:0];
                        state_reg <= ST_PCM_M1;
                    end
                end
                ST_PCM_M1:
                begin
                    state_reg <= ST_PCM_M2;
                end
                ST_PCM_M2:
                begin
                    acc_reg   <= prod;
                    state_reg <= ST_PCM_SUM;
                end
                ST_PCM_SUM:
                begin
                    state_reg <= ST_PCM_DIV;
                end
                ST_PCM_DIV:
                begin
                    if (div_done)
                    begin
                        nxt_reg <= nxt_reg + 27'd1;
                        if (fin_reg)
                        begin
                            emit_pcm_reg   <= pcm_v;
                            emit_end_reg   <= last_out;
                            emit_empty_reg <= 1'b0;
                            ret_state_reg  <= ST_FLOOP_CHK;
                            state_reg      <= ST_EMIT;
                        end
                        else if (hold)
                        begin
                            // keep the newest value back, release the older one
                            held_output_reg <= pcm_v;
                            held_valid_reg  <= 1'b1;
                            if (held_valid_reg)
                            begin
                                emit_pcm_reg   <= held_output_reg;
                                emit_end_reg   <= 1'b0;
                                emit_empty_reg <= 1'b0;
                                ret_state_reg  <= ST_LOOP_CHK;
                                state_reg      <= ST_EMIT;
                            end
                            else
                            begin
                                state_reg <= ST_LOOP_CHK;
                            end
                        end
                        else
                        begin
                            emit_pcm_reg   <= pcm_v;
                            emit_end_reg   <= 1'b0;
                            emit_empty_reg <= 1'b0;
                            ret_state_reg  <= ST_LOOP_CHK;
                            state_reg      <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        n_reg     <= n_reg + 4'd1;
                        state_reg <= ret_state_reg;
                    end
                end
                ST_T_MUL:
                begin
                    state_reg <= ST_T_DIV;
                end
                ST_T_DIV:
                begin
                    state_reg <= ST_T_WAIT;
                end
                ST_T_WAIT:
                begin
                    if (div_done)
                    begin
                        if (mono_count_reg == 25'd1 || div_quot == '0)
                            t_reg <= 28'd1;
                        else
                            t_reg <= div_quot;
                        state_reg <= ST_LAST_MUL;
                    end
                end
                ST_LAST_MUL:
                begin
                    state_reg <= ST_LAST_SAVE;
                end
                ST_LAST_SAVE:
                begin
                    limpos_reg     <= pos;
                    n_reg          <= '0;
                    held_valid_reg <= 1'b0;
                    if (held_valid_reg && held_due)
                    begin
                        emit_pcm_reg   <= held_output_reg;
                        emit_end_reg   <= !((nxt_w < t_reg) && (nxt_reg != IDX_LAST));
                        emit_empty_reg <= 1'b0;
                        ret_state_reg  <= ST_FLOOP_CHK;
                        state_reg      <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_FLOOP_CHK;
                    end
                end
                ST_FLOOP_CHK:
                begin
                    if (floop_run)
                    begin
                        state_reg <= ST_POS_MUL;
                    end
                    else if (n_reg == '0)
                    begin
                        // held value dropped and nothing else due
                        emit_pcm_reg   <= '0;
                        emit_end_reg   <= 1'b1;
                        emit_empty_reg <= 1'b0;
                        ret_state_reg  <= ST_CLEAR;
                        state_reg      <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_CLEAR;
                    end
                end
                ST_CLEAR:
                begin
                    frame_sum_reg     <= '0;
                    channels_seen_reg <= '0;
                    previous_mono_reg <= '0;
                    current_mono_reg  <= '0;
                    mono_count_reg    <= '0;
                    nxt_reg           <= '0;
                    held_output_reg   <= '0;
                    held_valid_reg    <= 1'b0;
                    state_reg         <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_EMIT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            out_pcm_reg   <= emit_pcm_reg;
            out_end_reg   <= emit_end_reg;
            out_empty_reg <= emit_empty_reg;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.pcm       = out_pcm_reg;
    assign results.run_end   = out_end_reg;
    assign results.empty_res = out_empty_reg;

    // no more than the per-sample result budget
    a_result_budget: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MAX_RESULTS) else $error("result budget exceeded");
    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        channels_seen_reg < MAX_CHANNELS) else $error("frame overran channel limit");
    a_clear_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> (mono_count_reg == '0 && !held_valid_reg))
        else $error("recording state not cleared");
    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && ret_state_reg == ST_CLEAR) |-> emit_end_reg)
        else $error("closing result lacks run_end");

endmodule

>>> sv/adrs_mul.sv
// shared signed multiplier with registered product
module adrs_mul (
    input  logic                             clk,
    input  logic signed [adrs_pkg::MUL_A_W-1:0] a,
    input  logic signed [adrs_pkg::MUL_B_W-1:0] b,
    output logic signed [adrs_pkg::MUL_P_W-1:0] prod
);
    import adrs_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    // one product per cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

>>> sv/adrs_div.sv
// shared restoring divider, one quotient bit per cycle
module adrs_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  adrs_pkg::div_req_t             req,
    input  logic [adrs_pkg::DIV_N_W-1:0]   num,
    input  logic [adrs_pkg::DIV_D_W-1:0]   den,
    output logic                           done,
    output logic [adrs_pkg::DIV_Q_W-1:0]   quot,
    output logic [adrs_pkg::DIV_D_W-1:0]   rem
);
    import adrs_pkg::*;

    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_N_W-1:0] nb_reg;
    logic [DIV_Q_W-1:0] q_reg;
    logic [DIV_C_W-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DIV_D_W:0]   trial;
    logic               ge;
    logic [DIV_D_W:0]   diff;

    // one trial subtract per cycle
    assign trial = {rem_reg, nb_reg[DIV_N_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            unique case (req.shift)
                DIV_S16: cnt_reg <= 6'd16;
                DIV_S28: cnt_reg <= 6'd28;
                DIV_S45: cnt_reg <= 6'd45;
                default: cnt_reg <= 6'd45;
            endcase
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath: high numerator bits preload the remainder
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= den;
            q_reg   <= '0;
            unique case (req.shift)
                DIV_S16:
                begin
                    rem_reg <= num[59:16];
                    nb_reg  <= {num[15:0], 44'd0};
                end
                DIV_S28:
                begin
                    rem_reg <= {12'd0, num[59:28]};
                    nb_reg  <= {num[27:0], 32'd0};
                end
                default:
                begin
                    rem_reg <= {29'd0, num[59:45]};
                    nb_reg  <= {num[44:0], 15'd0};
                end
            endcase
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            nb_reg  <= {nb_reg[DIV_N_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;

    // a new division starts only on an idle unit
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg) else $error("divider restarted while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != 6'd0) else $error("divider busy with no bits left");

endmodule

>>> dv/adrs_checker.sv
// checker for the downmix / resample / pcm16 block: predicts and compares results
`timescale 1ns / 1ps

module adrs_checker
    import adrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    adrs_in_if                    samples,
    adrs_out_if                   results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam longint Q_ONE     = 64'd4194304;
    localparam longint MONO_MAX  = 64'd16777216;
    localparam longint INDEX_CAP = 64'd134217727;
    localparam int     STEP_CAP  = 8;

    typedef struct packed {
        logic [PCM_W-1:0] pcm;
        logic             run_end;
        logic             empty_res;
    } pcm_result_t;

    pcm_result_t pcm_expected_q[$];

    // register shadows
    logic [CHAN_W-1:0] chan_reg;
    logic [RATE_W-1:0] in_rate_reg;
    logic [RATE_W-1:0] out_rate_reg;

    // recording state
    longint frame_acc, mono_prev, mono_cur, mono_total, next_k, held_pcm;
    int     chans_got;
    bit     held_ok;
    int     step_n;

    assign pending = pcm_expected_q.size();

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q--;
        return q;
    endfunction

    // interpolate, clamp to +-1.0 and scale to pcm16
    function automatic longint interp_pcm(longint a, longint b, longint r, longint o);
        longint num, lim;
        num = a * o + (b - a) * r;
        lim = Q_ONE * o;
        if (num > lim) num = lim;
        if (num < -lim) num = -lim;
        return floor_quot(num * 65534 + lim, 2 * lim);
    endfunction

    task automatic emit(longint pcm, bit last, bit empty);
        pcm_result_t r;
        r.pcm       = pcm[PCM_W-1:0];
        r.run_end   = last;
        r.empty_res = empty;
        pcm_expected_q.push_back(r);
        step_n++;
    endtask

    task automatic clear_recording();
        frame_acc  = 0;
        chans_got  = 0;
        mono_prev  = 0;
        mono_cur   = 0;
        mono_total = 0;
        next_k     = 0;
        held_pcm   = 0;
        held_ok    = 0;
    endtask

    // expected results of one accepted channel sample
    task automatic absorb_sample(logic [SAMPLE_W-1:0] smp, logic fin);
        longint s, c, ir, orr, k, lim, t, lastpos, v;
        bit     hold, fresh;
        s = longint'($signed(smp));
        c = chan_reg;
        ir = in_rate_reg;
        orr = out_rate_reg;
        fresh = 0;
        step_n = 0;
        if (c < 1) c = 1;
        if (c > MAX_CHANNELS) c = MAX_CHANNELS;
        if (ir < 1) ir = 1;
        if (orr < 1) orr = 1;
        if (orr > 4 * ir) orr = 4 * ir;
        hold = orr < ir;

        // frame downmix
        frame_acc += s;
        chans_got++;
        if (chans_got >= c) begin
            longint mono;
            mono = floor_quot(2 * frame_acc + c, 2 * c);
            frame_acc = 0;
            chans_got = 0;
            if (mono_total < MONO_MAX) begin
                mono_prev = mono_cur;
                mono_cur  = mono;
                mono_total++;
                fresh = 1;
            end
        end

        // outputs inside the recording
        if (!fin) begin
            if (fresh && mono_total >= 2) begin
                lim = (mono_total - 1) * orr;
                if (!hold && held_ok) begin
                    emit(held_pcm, 0, 0);
                    held_ok = 0;
                end
                for (k = next_k; k < INDEX_CAP && k * ir < lim && step_n < STEP_CAP; k++) begin
                    v = interp_pcm(mono_prev, mono_cur, (k * ir) % orr, orr);
                    if (hold) begin
                        if (held_ok) emit(held_pcm, 0, 0);
                        held_pcm = v;
                        held_ok  = 1;
                    end
                    else begin
                        emit(v, 0, 0);
                    end
                end
                next_k = k;
            end
            return;
        end

        // end of recording
        if (mono_total == 0) begin
            emit(0, 1, 1);
        end
        else begin
            t = (2 * mono_total * orr + ir) / (2 * ir);
            lastpos = (mono_total - 1) * orr;
            if (t < 1 || mono_total == 1) t = 1;
            if (held_ok && next_k != 0 && next_k - 1 < t)
                emit(held_pcm, 0, 0);
            held_ok = 0;
            for (k = next_k; k < t && k < INDEX_CAP && step_n < STEP_CAP; k++) begin
                if (k * ir >= lastpos)
                    v = interp_pcm(mono_cur, mono_cur, 0, orr);
                else
                    v = interp_pcm(mono_prev, mono_cur, (k * ir) % orr, orr);
                emit(v, 0, 0);
            end
            if (step_n == 0)
                emit(0, 1, 0);
            else
                pcm_expected_q[pcm_expected_q.size()-1].run_end = 1'b1;
        end
        clear_recording();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            chan_reg     <= CHANNEL_COUNT_RST;
            in_rate_reg  <= INPUT_RATE_RST;
            out_rate_reg <= OUTPUT_RATE_RST;
            clear_recording();
            pcm_expected_q.delete();
            errors = 0;
        end
        else begin
            // result transfer against the oldest expectation
            if (results.valid && results.ready) begin
                if (pcm_expected_q.size() == 0) begin
                    $error("unexpected result pcm=%0d run_end=%0b empty_res=%0b",
                           $signed(results.pcm), results.run_end, results.empty_res);
                    errors++;
                end
                else begin
                    pcm_result_t e;
                    e = pcm_expected_q.pop_front();
                    if (results.pcm !== e.pcm) begin
                        $error("pcm: expected %0d, got %0d", $signed(e.pcm),
                               $signed(results.pcm));
                        errors++;
                    end
                    if (results.run_end !== e.run_end) begin
                        $error("run_end: expected %0b, got %0b", e.run_end, results.run_end);
                        errors++;
                    end
                    if (results.empty_res !== e.empty_res) begin
                        $error("empty_res: expected %0b, got %0b", e.empty_res,
                               results.empty_res);
                        errors++;
                    end
                end
            end
            // sample transfer
            if (samples.valid && samples.ready)
                absorb_sample(samples.sample, samples.final_req);
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CHANNEL_COUNT: chan_reg     <= cfg_data[CHAN_W-1:0];
                    CFG_INPUT_RATE:    in_rate_reg  <= cfg_data[RATE_W-1:0];
                    CFG_OUTPUT_RATE:   out_rate_reg <= cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> dv/tb.sv
// testbench top: stimulus, handshake pacing and verdict for the resampler
`timescale 1ns / 1ps

module tb;
    import adrs_pkg::*;

    localparam int SETTLE_CYCLES = 1000;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int RANDOM_ITEMS  = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    cycles;
    int                    sent;
    bit                    no_idle;
    int                    chans_now;

    adrs_in_if  samples ();
    adrs_out_if results ();

    audio_downmix_resample_pcm16 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    adrs_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // timeout
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result receiver with random stalls
    initial
    begin
        int n;
        results.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                results.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            results.ready <= 1'b1;
            @(posedge clk);
            while (!results.valid) @(posedge clk);
        end
    end

    task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic fin);
        int n;
        n = no_idle ? 0 : $urandom_range(0, 10);
        if (n > 0) begin
            samples.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        samples.valid     <= 1'b1;
        samples.sample    <= smp;
        samples.final_req <= fin;
        @(posedge clk);
        while (!samples.ready) @(posedge clk);
        sent++;
    endtask

    // drain all results, then let the block settle
    task automatic drain();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; the caller drops the write enable afterwards
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_regs(int ch, int ir, int orr);
        drain();
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(ch));
        write_reg(CFG_INPUT_RATE, CFG_DATA_W'(ir));
        write_reg(CFG_OUTPUT_RATE, CFG_DATA_W'(orr));
        cfg_we    <= 1'b0;
        chans_now = ch;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h400000;
            3: return 24'hC00000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // one recording of whole frames plus an optional partial frame
    task automatic recording(int frames, int partial);
        int ch, total;
        ch = (chans_now < 1) ? 1 : ((chans_now > 8) ? 8 : chans_now);
        total = frames * ch + partial;
        if (total < 1) total = 1;
        for (int i = 0; i < total; i++)
            send_sample(pick_sample(), i == total - 1);
    endtask

    initial
    begin
        samples.valid     = 1'b0;
        samples.sample    = '0;
        samples.final_req = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_CHANNEL_COUNT;
        cfg_data  = '0;
        sent      = 0;
        no_idle   = 1'b0;
        chans_now = 1;
        rst_n     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default registers, single mono sample, extremes
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h000000, 1'b1);

        // empty recording and partial final frame with two channels
        set_regs(2, 48000, 48000);
        send_sample(24'h400000, 1'b1);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h123456, 1'b1);

        // zero channel count and zero rates, full upsample ratio
        set_regs(0, 0, 0);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b1);
        set_regs(15, 48000, 192000);
        recording(3, 3);

        // output rate saturated, then heavy downsampling with held outputs
        set_regs(1, 1, 262143);
        recording(4, 0);
        set_regs(1, 262143, 1);
        recording(5, 0);

        // random recordings over varying settings
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            int ch, ir, orr;
            ch = $urandom_range(0, 15);
            case ($urandom_range(0, 4))
                0: begin ir = 1; orr = 262143; end
                1: begin ir = 262143; orr = $urandom_range(1, 262143); end
                2: begin ir = 48000; orr = 16000; end
                3: begin ir = 44100; orr = 192000; end
                default: begin
                    ir  = $urandom_range(0, 262143);
                    orr = $urandom_range(0, 262143);
                end
            endcase
            set_regs(ch, ir, orr);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3))
                recording($urandom_range(0, 6), $urandom_range(0, 2));
        end
        no_idle = 1'b0;

        drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
sv/adrs_pkg.sv
sv/adrs_if.sv
sv/adrs_mul.sv
sv/adrs_div.sv
sv/audio_downmix_resample_pcm16.sv
dv/adrs_checker.sv
dv/tb.sv
